### rtl/mfe_pkg.sv
// ============================================================================
// mfe_pkg
// Shared constants and types for the median and moving-average filter.
// ============================================================================
package mfe_pkg;

    // Fraction bits of the running average and width of the Q0.16 weight.
    localparam int FRAC_BITS   = 16;
    localparam int WEIGHT_BITS = 16;

    // Reset value of the smoothing weight: 0.88 in Q0.16.
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 16'd57672;

    typedef logic [WEIGHT_BITS-1:0] weight_t;

endpackage

### rtl/median5_ema_filter_unit.sv
// ============================================================================
// median5_ema_filter_unit
// Median-of-window filter followed by a fixed-point moving average.
// ============================================================================
// One sample is accepted per cycle and gives one result: the accepted
// sample enters the history register, and when the stage advances the
// rank-based median network and the single multiply-add of the average
// update produce the result register. A result waiting on out_ready holds
// the history stage, so the sustained rate is one transaction per cycle
// whenever the consumer keeps up. The history and average clear to zero at
// reset, so the first medians include those zeros. The smoothing weight is
// Q0.16 (reset 0.88) and should be written only while the block is idle.
module median5_ema_filter_unit #(
    parameter int WINDOW      = 5,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] median_value,
    output logic signed [SAMPLE_BITS-1:0] estimate,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  mfe_pkg::weight_t              cfg_data
);
    import mfe_pkg::*;

    logic signed [SAMPLE_BITS-1:0] history_reg [WINDOW];
    logic                          stage_valid_reg;
    logic                          out_valid_reg;
    weight_t                       weight_reg;
    logic                          advance;
    logic                          in_fire;
    logic signed [SAMPLE_BITS-1:0] median;

    // Handshake: the history stage moves on when the result slot frees up.
    assign advance   = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !stage_valid_reg || advance;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    // Smoothing weight register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= WEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            weight_reg <= cfg_data;
        end
    end

    // Sample history, newest first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                history_reg[i] <= '0;
            end
        end
        else if (in_fire)
        begin
            history_reg[0] <= sample;
            for (int i = 1; i < WINDOW; i++)
            begin
                history_reg[i] <= history_reg[i-1];
            end
        end
    end

    // Stage and result valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    mfe_median #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_median (
        .hist   (history_reg),
        .median (median)
    );

    mfe_ema #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ema (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .weight       (weight_reg),
        .median       (median),
        .median_out   (median_value),
        .estimate_out (estimate)
    );

    // An accepted transaction always occupies the history stage next cycle.
    a_fire_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> stage_valid_reg)
        else $error("accepted sample did not reach the history stage");

    // A stage that moves on always produces a result.
    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("history stage advanced without a result");

    // With nothing in the stage, a taken result leaves the slot empty.
    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (!stage_valid_reg && out_valid_reg && out_ready) |=> !out_valid_reg)
        else $error("result repeated after it was taken");

    // A stalled stage holds the newest history entry.
    a_stall_holds_history: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !advance) |=> $stable(history_reg[0]))
        else $error("history changed while the stage was stalled");

endmodule

### rtl/mfe_median.sv
// ============================================================================
// mfe_median
// Combinational median select over the sample history by stable ranking.
// ============================================================================
module mfe_median #(
    parameter int WINDOW      = 5,
    parameter int SAMPLE_BITS = 16
) (
    input  logic signed [SAMPLE_BITS-1:0] hist [WINDOW],
    output logic signed [SAMPLE_BITS-1:0] median
);
    import mfe_pkg::*;

    localparam int RANK_BITS = $clog2(WINDOW);
    localparam logic [RANK_BITS-1:0] MID = RANK_BITS'(WINDOW / 2);

    logic [RANK_BITS-1:0] rank [WINDOW];

    // Each entry's position in an ascending stable sort: smaller entries,
    // plus equal entries that sit at a lower index.
    always_comb
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW; j++)
            begin
                if ((hist[j] < hist[i]) || ((j < i) && (hist[j] == hist[i])))
                begin
                    rank[i] = rank[i] + RANK_BITS'(1);
                end
            end
        end
    end

    // Exactly one entry holds the middle rank.
    always_comb
    begin
        median = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            if (rank[i] == MID)
            begin
                median = hist[i];
            end
        end
    end

endmodule

### rtl/mfe_ema.sv
// ============================================================================
// mfe_ema
// Moving-average update with one multiply, plus the result registers.
// ============================================================================
module mfe_ema #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  mfe_pkg::weight_t              weight,
    input  logic signed [SAMPLE_BITS-1:0] median,
    output logic signed [SAMPLE_BITS-1:0] median_out,
    output logic signed [SAMPLE_BITS-1:0] estimate_out
);
    import mfe_pkg::*;

    localparam int AVG_BITS  = SAMPLE_BITS + FRAC_BITS;
    localparam int DIFF_BITS = AVG_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + WEIGHT_BITS + 1;
    localparam logic signed [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) <<< (FRAC_BITS - 1);

    logic signed [AVG_BITS-1:0]    avg_reg;
    logic signed [AVG_BITS-1:0]    avg_next;
    logic signed [AVG_BITS-1:0]    med_q;
    logic signed [DIFF_BITS-1:0]   diff;
    logic signed [PROD_BITS-1:0]   prod;
    logic signed [PROD_BITS-1:0]   scaled;
    logic signed [SAMPLE_BITS-1:0] median_reg;
    logic signed [SAMPLE_BITS-1:0] estimate_reg;
    logic signed [SAMPLE_BITS-1:0] estimate_next;

    // The update w*avg + (1-w)*med is rewritten as med + w*(avg - med),
    // so a single multiply sits in the loop; rounding is half up.
    always_comb
    begin
        med_q    = {median, {FRAC_BITS{1'b0}}};
        diff     = DIFF_BITS'(avg_reg) - DIFF_BITS'(med_q);
        prod     = $signed({1'b0, weight}) * diff;
        scaled   = (prod + ROUND_HALF) >>> FRAC_BITS;
        avg_next = med_q + AVG_BITS'(scaled);
    end

    // The average stays inside the sample range, so rounding cannot overflow.
    assign estimate_next = avg_next[AVG_BITS-1:FRAC_BITS]
                         + SAMPLE_BITS'(avg_next[FRAC_BITS-1]);

    // Running average.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg <= '0;
        end
        else if (advance)
        begin
            avg_reg <= avg_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            median_reg   <= median;
            estimate_reg <= estimate_next;
        end
    end

    assign median_out   = median_reg;
    assign estimate_out = estimate_reg;

endmodule
